@@ hdl/nv12_block_to_rgb_defines.svh @@
// Assertion macros shared by the NV12 block to RGB design.
// Depends on nothing; files that assert take it in by include.
`ifndef NV12_BLOCK_TO_RGB_DEFINES_SVH
`define NV12_BLOCK_TO_RGB_DEFINES_SVH

// Checked at every rising edge of clk, switched off while rst_n is low.
`define N2R_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define N2R_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/n2r_pkg.sv @@
// Package of the NV12 block to RGB converter: coefficients, widths, types
// and the saturating shift. Depends on nothing.
package n2r_pkg;

    // BT.601 coefficients in fixed point with 16 fractional bits.
    localparam int COEF_Y     = 76309;
    localparam int COEF_RV    = 104597;
    localparam int COEF_GU    = 25675;
    localparam int COEF_GV    = 53279;
    localparam int COEF_BU    = 132201;
    localparam int LUMA_OFS   = 16;
    localparam int FRAC_W     = 16;

    // Pixels in one 2x2 block, and so the number of lanes.
    localparam int NUM_LANES  = 4;

    // Width of one registered product: the largest magnitude is 132201*128
    // for the blue term and 76309*239 for luma, both below 2^25.
    localparam int TERM_W     = 26;
    // Width of a sum of up to three products.
    localparam int SUM_W      = 28;
    // Width of a sum after the fractional bits are dropped.
    localparam int INT_W      = SUM_W - FRAC_W;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Chroma products shared by the four pixels of a block.
    typedef struct packed {
        term_t r_term;
        term_t gu_term;
        term_t gv_term;
        term_t b_term;
    } chroma_terms_t;

    // One converted pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Arithmetic shift by the fraction width, then clamp to 0..255.
    function automatic logic [7:0] sat_shift(input sum_t sum);
        logic signed [INT_W-1:0] whole;
        logic [7:0]              result;
        whole = INT_W'(sum >>> FRAC_W);
        if (whole < 0)
        begin
            result = 8'd0;
        end
        else if (whole > $signed(INT_W'(255)))
        begin
            result = 8'd255;
        end
        else
        begin
            result = whole[7:0];
        end
        return result;
    endfunction

endpackage

@@ hdl/n2r_ifs.sv @@
// Valid/ready interfaces of the NV12 block to RGB converter: the block
// channel in and the pixel channel out. Depends on nothing.
interface nv12_block_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    modport source (
        output valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_blue, chroma_red,
        input  ready
    );
    modport sink (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_blue, chroma_red,
        output ready
    );
endinterface

interface rgb_block_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;

    modport source (
        output valid, red_top_left, green_top_left, blue_top_left,
               red_top_right, green_top_right, blue_top_right,
               red_bottom_left, green_bottom_left, blue_bottom_left,
               red_bottom_right, green_bottom_right, blue_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, red_top_left, green_top_left, blue_top_left,
               red_top_right, green_top_right, blue_top_right,
               red_bottom_left, green_bottom_left, blue_bottom_left,
               red_bottom_right, green_bottom_right, blue_bottom_right,
        output ready
    );
endinterface

@@ hdl/nv12_block_to_rgb.sv @@
// Top level of the NV12 2x2 block to RGB24 converter: product stage, four
// pixel lanes and the merging output register. Depends on n2r_pkg, n2r_ifs,
// n2r_chroma, n2r_lane and nv12_block_to_rgb_defines.svh.
//
//   Channel   Role    Item
//   blocks    sink    four luma samples and the Cb and Cr bytes of one block
//   pixels    source  red, green and blue of the four pixels of the block
//
// One block is taken in every cycle unless the output stalls with both stages
// full, when the input is held off. A result passes through two stages, the
// multiplier registers and then the output register. Each stage refills
// whenever its content moves on, so a block is still taken while a result
// waits at the output as long as the product stage is free. Reset clears
// only the valid flags of the two stages.
`include "nv12_block_to_rgb_defines.svh"

module nv12_block_to_rgb (
    input  logic          clk,
    input  logic          rst_n,
    nv12_block_if.sink    blocks,
    rgb_block_if.source   pixels
);
    import n2r_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          s1_load;
    logic          out_load;
    logic [7:0]    luma [NUM_LANES];
    chroma_terms_t terms;
    pixel_t        lane_px [NUM_LANES];
    pixel_t        px_reg  [NUM_LANES];

    // Stage control: each stage loads when it is empty or being emptied.
    assign out_load      = s1_valid_reg && (!out_valid_reg || pixels.ready);
    assign blocks.ready  = !s1_valid_reg || out_load;
    assign s1_load       = blocks.valid && blocks.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Shared chroma products.
    n2r_chroma u_chroma (
        .clk         (clk),
        .load        (s1_load),
        .chroma_blue (blocks.chroma_blue),
        .chroma_red  (blocks.chroma_red),
        .terms       (terms)
    );

    // Luma samples in lane order: top left, top right, bottom left, bottom right.
    assign luma[0] = blocks.luma_top_left;
    assign luma[1] = blocks.luma_top_right;
    assign luma[2] = blocks.luma_bottom_left;
    assign luma[3] = blocks.luma_bottom_right;

    // Four pixel lanes working side by side.
    for (genvar lane = 0; lane < NUM_LANES; lane++)
    begin : g_lane
        n2r_lane u_lane (
            .clk   (clk),
            .load  (s1_load),
            .luma  (luma[lane]),
            .terms (terms),
            .pixel (lane_px[lane])
        );
    end

    // Merging stage: the four lane results form one output item.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                px_reg[i] <= lane_px[i];
            end
        end
    end

    assign pixels.valid              = out_valid_reg;
    assign pixels.red_top_left       = px_reg[0].red;
    assign pixels.green_top_left     = px_reg[0].green;
    assign pixels.blue_top_left      = px_reg[0].blue;
    assign pixels.red_top_right      = px_reg[1].red;
    assign pixels.green_top_right    = px_reg[1].green;
    assign pixels.blue_top_right     = px_reg[1].blue;
    assign pixels.red_bottom_left    = px_reg[2].red;
    assign pixels.green_bottom_left  = px_reg[2].green;
    assign pixels.blue_bottom_left   = px_reg[2].blue;
    assign pixels.red_bottom_right   = px_reg[3].red;
    assign pixels.green_bottom_right = px_reg[3].green;
    assign pixels.blue_bottom_right  = px_reg[3].blue;

    // A new result only ever comes from an occupied product stage.
    `N2R_ASSERT(a_out_from_s1, $rose(out_valid_reg) |-> $past(s1_valid_reg),
        "result appeared without a block in the product stage")
    // A block held in the product stage is not lost while the output stalls.
    `N2R_ASSERT(a_s1_kept, (s1_valid_reg && !out_load) |=> s1_valid_reg,
        "block in the product stage dropped")
    // A result taken with a block behind it is followed at once.
    `N2R_ASSERT(a_no_bubble, (out_valid_reg && pixels.ready && s1_valid_reg) |=> out_valid_reg,
        "bubble inserted behind a taken result")
    // The input is never refused while the product stage is empty.
    `N2R_ASSERT_ALWAYS(a_ready_empty, !s1_valid_reg |-> blocks.ready,
        "block refused with the product stage empty")

endmodule

@@ hdl/n2r_chroma.sv @@
// Chroma stage: forms the four chroma products of one block once and
// registers them for the lanes. Depends on n2r_pkg.
module n2r_chroma (
    input  logic                   clk,
    input  logic                   load,
    input  logic [7:0]             chroma_blue,
    input  logic [7:0]             chroma_red,
    output n2r_pkg::chroma_terms_t terms
);
    import n2r_pkg::*;

    logic signed [8:0] u_ofs;
    logic signed [8:0] v_ofs;
    chroma_terms_t     terms_reg;
    chroma_terms_t     terms_next;

    // Removing the offset of 128 is an inversion of the top bit, which then
    // becomes the sign and is extended by one place.
    assign u_ofs = signed'({~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]});
    assign v_ofs = signed'({~chroma_red[7], ~chroma_red[7], chroma_red[6:0]});

    // One multiplier for each chroma coefficient.
    always_comb
    begin
        terms_next.r_term  = TERM_W'(v_ofs * signed'(TERM_W'(COEF_RV)));
        terms_next.gu_term = TERM_W'(u_ofs * signed'(TERM_W'(COEF_GU)));
        terms_next.gv_term = TERM_W'(v_ofs * signed'(TERM_W'(COEF_GV)));
        terms_next.b_term  = TERM_W'(u_ofs * signed'(TERM_W'(COEF_BU)));
    end

    // Product register; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

@@ hdl/n2r_lane.sv @@
// One pixel lane: scales its luma sample, registers it, then adds the shared
// chroma terms and saturates the three colours. Depends on n2r_pkg.
module n2r_lane (
    input  logic                   clk,
    input  logic                   load,
    input  logic [7:0]             luma,
    input  n2r_pkg::chroma_terms_t terms,
    output n2r_pkg::pixel_t        pixel
);
    import n2r_pkg::*;

    logic signed [8:0] luma_ofs;
    term_t             ys_reg;
    term_t             ys_next;
    sum_t              sum_red;
    sum_t              sum_green;
    sum_t              sum_blue;

    // Luma scaling, registered alongside the chroma products.
    assign luma_ofs = signed'({1'b0, luma}) - signed'(9'(LUMA_OFS));
    assign ys_next  = TERM_W'(luma_ofs * signed'(TERM_W'(COEF_Y)));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ys_reg <= ys_next;
        end
    end

    // Colour sums in full precision.
    assign sum_red   = SUM_W'(ys_reg) + SUM_W'(terms.r_term);
    assign sum_green = SUM_W'(ys_reg) - SUM_W'(terms.gu_term) - SUM_W'(terms.gv_term);
    assign sum_blue  = SUM_W'(ys_reg) + SUM_W'(terms.b_term);

    // Drop the fraction and clamp each colour.
    always_comb
    begin
        pixel.red   = sat_shift(sum_red);
        pixel.green = sat_shift(sum_green);
        pixel.blue  = sat_shift(sum_blue);
    end

endmodule
